[sv/sspe_pkg.sv]
// Shared types and constants for the stepper segment pulse executor.
package sspe_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ANGLE_FRAC_DEF  = 16;

  // angle diff (33) times steps per rev (17), plus residue
  localparam int PROD_W = 50;
  localparam int TOT_W  = 51;

  localparam logic [1:0] CFG_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_SPR      = 2'd1;
  localparam logic [1:0] CFG_MODE     = 2'd2;

  typedef enum logic [1:0] {
    K_TICK  = 2'd0,
    K_START = 2'd1,
    K_PUSH  = 2'd2,
    K_NOP   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [1:0] pulses;
    logic       direction;
    logic       running;
    logic       push_accepted;
    logic       finished;
    logic [4:0] level;
  } result_t;

endpackage

[sv/sspe_div.sv]
// Restoring divider, one quotient bit per cycle.
module sspe_div #(
  parameter int N = 24,
  parameter int D = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);
  localparam int CNT_W = $clog2(N + 1);

  logic [CNT_W-1:0] cnt;
  logic [D-1:0]     dv;
  logic [D-1:0]     rem;
  logic [D:0]       trial;
  logic [D:0]       sub;
  logic             ge;

  assign trial = {rem, quotient[N-1]};
  assign sub   = trial - {1'b0, dv};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        rem      <= '0;
        dv       <= divisor;
        cnt      <= CNT_W'(N);
      end else if (cnt != '0) begin
        rem      <= ge ? sub[D-1:0] : trial[D-1:0];
        quotient <= {quotient[N-2:0], ge};
        cnt      <= cnt - 1'b1;
        done     <= (cnt == CNT_W'(1));
      end
    end
  end
endmodule

[sv/sspe_front.sv]
// Front end: accepts input beats, classifies the action, two-entry item queue.
module sspe_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     action,
  input  logic [31:0]    segment_value,
  input  logic           segment_last,
  output logic           q_valid,
  output sspe_pkg::item_t q_item,
  input  logic           q_take
);
  import sspe_pkg::*;

  item_t      ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  item_t      cls;

  always_comb begin
    cls.value = segment_value;
    cls.last  = segment_last;
    case (action)
      K_TICK:  cls.kind = K_TICK;
      K_START: cls.kind = K_START;
      K_PUSH:  cls.kind = K_PUSH;
      default: cls.kind = K_NOP;
    endcase
  end

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = ent[rp];

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (q_take) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_take};
    end
  end
endmodule

[sv/sspe_back.sv]
// Back end: configuration, segment queue, timing, step conversion and result register.
module sspe_back #(
  parameter int QUEUE_DEPTH     = sspe_pkg::QUEUE_DEPTH_DEF,
  parameter int ANGLE_FRAC_BITS = sspe_pkg::ANGLE_FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_data,
  input  logic              q_valid,
  input  sspe_pkg::item_t   q_item,
  output logic              q_take,
  output logic              out_valid,
  input  logic              out_stall,
  output sspe_pkg::result_t result
);
  import sspe_pkg::*;

  localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEN_W = 9 + ANGLE_FRAC_BITS;
  localparam int RES_W = DEN_W + 1;
  // 360 << F is 45 << (F + 3): shift, then divide by 45 in 16-bit digits
  localparam int SH    = ANGLE_FRAC_BITS + 3;
  localparam int QN_W  = 48;
  localparam logic [22:0] QRECIP = 23'd5965233;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_POP, S_MUL, S_SUM, S_QDIV, S_APPLY, S_PDIV, S_STEP, S_FIN
  } state_t;

  state_t state;

  logic [23:0] interval;
  logic [15:0] spr;
  logic        pmode;

  logic [31:0] now_t;
  logic [31:0] nit;
  logic [31:0] nst;
  logic [31:0] period;
  logic [31:0] steps_left;
  logic        dir;
  logic        active;
  logic        last_taken;
  logic [QW-1:0] head;
  logic [CW-1:0] count;
  logic [31:0] ref_angle;
  logic        have_ref;
  logic signed [RES_W-1:0] residue;

  logic        is_tick;
  logic        done_r;
  logic [1:0]  pulses;
  logic        accepted;

  logic signed [32:0]       diff;
  logic signed [PROD_W-1:0] prod;
  logic        tneg;
  logic [31:0] mag;
  logic        sneg;
  logic        snz;

  logic [32:0] mem [QUEUE_DEPTH];
  logic [32:0] rd_data;
  logic        mem_we;
  logic [QW-1:0] wslot;
  logic [CW:0]   wsum;

  logic        div_start;
  logic        div_done;
  logic [23:0] div_quo;

  logic [QN_W-1:0] qn;
  logic [5:0]      qr;
  logic [1:0]      qc;
  logic [SH-1:0]   qlow;
  logic [21:0]     qx;
  logic [44:0]     qp;
  logic [15:0]     qdig;
  logic [21:0]     qback;

  logic signed [TOT_W-1:0] total_c;
  logic [TOT_W-1:0]        total_abs;
  logic [RES_W-1:0]        rem_ext;
  logic                    out_load;
  logic                    endc;
  logic [31:0]             v;
  logic                    lt_n;
  logic [CW-1:0]           cnt_n;
  logic [QW-1:0]           head_n;
  logic [CW+4:0]           lvl_ext;

  assign q_take = (state == S_IDLE) && q_valid;

  assign wsum  = (CW+1)'(head) + (CW+1)'(count);
  assign wslot = (wsum >= (CW+1)'(QUEUE_DEPTH)) ? QW'(wsum - (CW+1)'(QUEUE_DEPTH)) : QW'(wsum);
  assign mem_we = q_take && (q_item.kind == K_PUSH) && (count < CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) mem[wslot] <= {q_item.value, q_item.last};
    if (state == S_FETCH) rd_data <= mem[head];
  end

  assign total_c   = TOT_W'(prod) + TOT_W'(residue);
  assign total_abs = total_c[TOT_W-1] ? TOT_W'(-total_c) : TOT_W'(total_c);

  assign qx      = {qr, qn[QN_W-1:QN_W-16]};
  assign qp      = {23'b0, qx} * {22'b0, QRECIP};
  assign qdig    = qp[43:28];
  assign qback   = qx - {6'b0, qdig} * 22'd45;
  assign rem_ext = RES_W'({qr, qlow});

  assign div_start = (state == S_APPLY) && (mag != '0);

  sspe_div #(.N(24), .D(32)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (interval),
    .divisor  (mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign v      = rd_data[32:1];
  assign lt_n   = last_taken | rd_data[0];
  assign cnt_n  = count - 1'b1;
  assign head_n = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign out_load = !out_valid || !out_stall;
  assign endc   = is_tick && active && last_taken && (steps_left == '0);
  assign lvl_ext = {5'b0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      interval   <= 24'd10000;
      spr        <= 16'd3200;
      pmode      <= 1'b0;
      now_t      <= '0;
      nit        <= '0;
      nst        <= '0;
      period     <= '0;
      steps_left <= '0;
      dir        <= 1'b0;
      active     <= 1'b0;
      last_taken <= 1'b0;
      head       <= '0;
      count      <= '0;
      ref_angle  <= '0;
      have_ref   <= 1'b0;
      residue    <= '0;
      out_valid  <= 1'b0;
      is_tick    <= 1'b0;
      done_r     <= 1'b0;
      pulses     <= '0;
      accepted   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_INTERVAL: interval <= cfg_data;
          CFG_SPR:      spr      <= cfg_data[15:0];
          CFG_MODE:     pmode    <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (q_valid) begin
            is_tick  <= (q_item.kind == K_TICK);
            done_r   <= 1'b0;
            pulses   <= '0;
            accepted <= 1'b0;
            case (q_item.kind)
              K_TICK: begin
                if (active && !(now_t - nit >= 32'h8000_0000)) state <= S_FETCH;
                else state <= S_STEP;
              end
              K_START: begin
                active     <= 1'b1;
                nit        <= now_t;
                steps_left <= '0;
                last_taken <= 1'b0;
                have_ref   <= 1'b0;
                residue    <= '0;
                state      <= S_FIN;
              end
              K_PUSH: begin
                if (mem_we) begin
                  count    <= count + 1'b1;
                  accepted <= 1'b1;
                end
                state <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_FETCH: begin
          if (last_taken || count == '0) begin
            active     <= 1'b0;
            steps_left <= '0;
            done_r     <= 1'b1;
            state      <= S_STEP;
          end else begin
            state <= S_POP;
          end
        end
        S_POP: begin
          last_taken <= lt_n;
          head       <= head_n;
          count      <= cnt_n;
          if (!pmode) begin
            mag   <= v[31] ? -v : v;
            sneg  <= v[31];
            snz   <= (v != '0);
            state <= S_APPLY;
          end else if (!have_ref) begin
            ref_angle <= v;
            have_ref  <= 1'b1;
            if (lt_n || cnt_n == '0) begin
              active     <= 1'b0;
              steps_left <= '0;
              done_r     <= 1'b1;
              state      <= S_STEP;
            end else begin
              state <= S_FETCH;
            end
          end else begin
            diff      <= $signed({v[31], v}) - $signed({ref_angle[31], ref_angle});
            ref_angle <= v;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(diff) * PROD_W'($signed({1'b0, spr}));
          state <= S_SUM;
        end
        S_SUM: begin
          tneg  <= total_c[TOT_W-1];
          qn    <= QN_W'(total_abs >> SH);
          qlow  <= total_abs[SH-1:0];
          qr    <= '0;
          qc    <= 2'd3;
          state <= S_QDIV;
        end
        S_QDIV: begin
          if (qc != '0) begin
            qn <= {qn[QN_W-17:0], qdig};
            qr <= qback[5:0];
            qc <= qc - 1'b1;
          end else begin
            mag     <= (|qn[QN_W-1:32]) ? 32'hFFFF_FFFF : qn[31:0];
            snz     <= (qn != '0);
            sneg    <= tneg;
            residue <= tneg ? $signed(-rem_ext) : $signed(rem_ext);
            state   <= S_APPLY;
          end
        end
        S_APPLY: begin
          nit        <= nit + 32'(interval);
          steps_left <= mag;
          if (snz) dir <= !sneg;
          if (mag != '0) begin
            state <= S_PDIV;
          end else begin
            period <= '0;
            state  <= S_STEP;
          end
        end
        S_PDIV: begin
          if (div_done) begin
            period     <= {8'b0, div_quo};
            pulses     <= 2'd1;
            steps_left <= steps_left - 1'b1;
            nst        <= now_t + {8'b0, div_quo};
            state      <= S_STEP;
          end
        end
        S_STEP: begin
          if (active && steps_left != '0 && !(now_t - nst >= 32'h8000_0000)) begin
            nst        <= nst + period;
            steps_left <= steps_left - 1'b1;
            pulses     <= pulses + 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            out_valid            <= 1'b1;
            result.pulses        <= pulses;
            result.direction     <= dir;
            result.running       <= active && !endc;
            result.push_accepted <= accepted;
            result.finished      <= done_r || endc;
            result.level         <= lvl_ext[4:0];
            if (endc) begin
              active     <= 1'b0;
              steps_left <= '0;
            end
            if (is_tick) now_t <= now_t + 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[sv/stepper_segment_pulse_executor_unit.sv]
// Stepper segment pulse executor: item front end, executor back end, result register.
// Path, input beat to result valid: front queue, then the back end's idle and finish states
// for start, push and unused codes. A tick also passes the step state; on an interval
// boundary it fetches first, and a popped segment adds pop, apply and, with steps, the
// period divide; position mode adds multiply, sum and quotient digits. Output stalls hold it.
// One item at a time. Reset (rst, synchronous): queue empty, run stopped, time zero.
module stepper_segment_pulse_executor_unit #(
  parameter int QUEUE_DEPTH     = sspe_pkg::QUEUE_DEPTH_DEF,
  parameter int ANGLE_FRAC_BITS = sspe_pkg::ANGLE_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] segment_value,
  input  logic        segment_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  step_pulses,
  output logic        direction,
  output logic        running,
  output logic        push_accepted,
  output logic        finished,
  output logic [4:0]  queue_level
);
  import sspe_pkg::*;

  logic    q_valid;
  item_t   q_item;
  logic    q_take;
  result_t result;

  sspe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .segment_value (segment_value),
    .segment_last  (segment_last),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_take        (q_take)
  );

  sspe_back #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign step_pulses   = result.pulses;
  assign direction     = result.direction;
  assign running       = result.running;
  assign push_accepted = result.push_accepted;
  assign finished      = result.finished;
  assign queue_level   = result.level;
endmodule

[bench/tb_stepper_segment_pulse_executor_unit.sv]
// Testbench for the stepper segment pulse executor: directed and random runs checked beat by beat.
module tb_stepper_segment_pulse_executor_unit;
  import sspe_pkg::*;

  localparam int QDEPTH = 16;
  localparam int FRAC = 16;
  localparam int SETTLE = 120;
  localparam int LIMIT = 3000000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [1:0] cfg_index = CFG_INTERVAL;
  logic [23:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] action = K_TICK;
  logic [31:0] segment_value = '0;
  logic segment_last = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] step_pulses;
  logic direction, running, push_accepted, finished;
  logic [4:0] queue_level;

  stepper_segment_pulse_executor_unit dut (.*);

  initial forever #5 clk = ~clk;

  // predictor state
  logic [23:0] p_interval;
  logic [15:0] p_spr;
  logic p_posmode;
  logic [31:0] now_t, next_iv, next_st, period, left;
  logic dir_q, active, last_taken, have_ref;
  logic [31:0] ref_angle;
  longint residue;
  logic [31:0] seg_val [QDEPTH];
  logic seg_lst [QDEPTH];
  int head, count;

  result_t expected_beats[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_stepper_segment_pulse_executor_unit: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= gap_len();
      out_stall <= ~out_stall;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit reached(logic [31:0] t, logic [31:0] mark);
    logic [31:0] d;
    d = t - mark;
    return d[31] == 0;
  endfunction

  function automatic logic [31:0] pop_seg();
    logic [31:0] v;
    v = seg_val[head];
    if (seg_lst[head]) last_taken = 1;
    head = (head + 1) % QDEPTH;
    count--;
    return v;
  endfunction

  function automatic bit fetch_steps(output longint steps);
    logic [31:0] a;
    longint diff, den, total, q;
    steps = 0;
    if (last_taken || count == 0) return 0;
    if (!p_posmode) begin
      steps = longint'(signed'(pop_seg()));
      return 1;
    end
    if (!have_ref) begin
      ref_angle = pop_seg();
      have_ref = 1;
      if (last_taken || count == 0) return 0;
    end
    a = pop_seg();
    diff = longint'(signed'(a)) - longint'(signed'(ref_angle));
    den = longint'(360) << FRAC;
    total = diff * longint'(p_spr) + residue;
    q = total / den;
    ref_angle = a;
    residue = total - q * den;
    steps = q;
    return 1;
  endfunction

  function automatic result_t predict_beat(logic [1:0] act, logic [31:0] val, logic lst);
    result_t r;
    logic [31:0] t;
    longint s;
    logic [63:0] mag;
    int pulses;
    bit acc, done;
    pulses = 0;
    acc = 0;
    done = 0;
    if (act == K_TICK) begin
      t = now_t;
      if (active) begin
        if (reached(t, next_iv)) begin
          if (!fetch_steps(s)) begin
            active = 0;
            left = 0;
            done = 1;
          end else begin
            mag = (s < 0) ? -s : s;
            if (mag > 64'hFFFFFFFF) mag = 64'hFFFFFFFF;
            next_iv = next_iv + p_interval;
            left = mag[31:0];
            if (s > 0) dir_q = 1;
            else if (s < 0) dir_q = 0;
            if (left > 0) begin
              period = p_interval / left;
              pulses++;
              left--;
              next_st = t + period;
            end else begin
              period = 0;
            end
          end
        end
        if (active && left > 0 && reached(t, next_st)) begin
          next_st = next_st + period;
          left--;
          pulses++;
        end
        if (active && last_taken && left == 0) begin
          active = 0;
          left = 0;
          done = 1;
        end
      end
      now_t = t + 1;
    end else if (act == K_START) begin
      active = 1;
      next_iv = now_t;
      left = 0;
      last_taken = 0;
      have_ref = 0;
      residue = 0;
    end else if (act == K_PUSH) begin
      if (count < QDEPTH) begin
        seg_val[(head + count) % QDEPTH] = val;
        seg_lst[(head + count) % QDEPTH] = lst;
        count++;
        acc = 1;
      end
    end
    r.pulses = pulses[1:0];
    r.direction = dir_q;
    r.running = active;
    r.push_accepted = acc;
    r.finished = done;
    r.level = count[4:0];
    return r;
  endfunction

  task automatic report_err(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_err("unexpected beat", 1, 0);
      end else begin
        e = expected_beats.pop_front();
        if (step_pulses !== e.pulses) report_err("step_pulses", step_pulses, e.pulses);
        if (direction !== e.direction) report_err("direction", direction, e.direction);
        if (running !== e.running) report_err("running", running, e.running);
        if (push_accepted !== e.push_accepted)
          report_err("push_accepted", push_accepted, e.push_accepted);
        if (finished !== e.finished) report_err("finished", finished, e.finished);
        if (queue_level !== e.level) report_err("queue_level", queue_level, e.level);
      end
    end
  end

  task automatic send(logic [1:0] act, logic [31:0] val, logic lst);
    int g;
    in_valid <= 1;
    action <= act;
    segment_value <= val;
    segment_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_beats.push_back(predict_beat(act, val, lst));
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    drain();
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 0;
    case (idx)
      CFG_INTERVAL: p_interval = data;
      CFG_SPR: p_spr = data[15:0];
      CFG_MODE: p_posmode = data[0];
      default: ;
    endcase
  endtask

  task automatic ticks(int n);
    repeat (n) send(K_TICK, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_step_mode_basic();
    write_reg(CFG_MODE, 0);
    write_reg(CFG_INTERVAL, 6);
    send(K_PUSH, 32'd3, 0);
    send(K_PUSH, 32'hFFFF_FFFE, 0);
    send(K_PUSH, 32'd0, 0);
    send(K_PUSH, 32'd7, 1);
    send(K_START, 0, 0);
    ticks(30);
  endtask

  task automatic test_queue_full();
    quiet = 1;
    repeat (QDEPTH + 2) send(K_PUSH, 32'd1, 0);
    quiet = 0;
    send(K_NOP, 32'hFFFF_FFFF, 1);
    send(K_START, 0, 0);
    ticks(4);
    send(K_START, 0, 0);
    ticks(4);
  endtask

  task automatic test_extremes();
    write_reg(CFG_INTERVAL, 0);
    send(K_PUSH, 32'h7FFF_FFFF, 0);
    send(K_PUSH, 32'h8000_0000, 1);
    send(K_START, 0, 0);
    ticks(4);
    write_reg(CFG_INTERVAL, 24'hFFFFFF);
    send(K_PUSH, 32'd2, 1);
    send(K_START, 0, 0);
    ticks(4);
    send(K_START, 0, 0);
    ticks(2);
    write_reg(CFG_INTERVAL, 1);
    ticks(3);
  endtask

  task automatic test_position_mode();
    write_reg(CFG_MODE, 1);
    write_reg(CFG_INTERVAL, 8);
    write_reg(CFG_SPR, 16'hFFFF);
    send(K_PUSH, 32'd0, 0);
    send(K_PUSH, 32'h0000_8000, 0);
    send(K_PUSH, 32'h8000_0000, 0);
    send(K_PUSH, 32'h7FFF_FFFF, 1);
    send(K_START, 0, 0);
    ticks(30);
    write_reg(CFG_SPR, 1);
    send(K_PUSH, 32'd5, 1);
    send(K_START, 0, 0);
    ticks(3);
    write_reg(CFG_SPR, 3200);
  endtask

  task automatic test_random();
    int n, k, done_items, seg;
    done_items = 0;
    while (done_items < 600) begin
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CFG_MODE, 24'($urandom_range(0, 1)));
        write_reg(CFG_INTERVAL,
                  24'(($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 12)));
        write_reg(CFG_SPR, 24'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 800)));
      end
      quiet = ($urandom_range(0, 5) == 0);
      n = $urandom_range(1, 5);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(0, 3))
          0: seg = $urandom;
          1: seg = $urandom_range(0, 8) - 4;
          default: seg = p_posmode ? $urandom_range(0, 2000000) - 1000000
                                   : $urandom_range(0, 20) - 10;
        endcase
        send(K_PUSH, seg, (k == n - 1) ? ($urandom_range(0, 4) != 0) : 1'b0);
      end
      send(K_START, $urandom, 1'($urandom_range(0, 1)));
      k = n * (p_interval + 1) + 4;
      if (k > 40) k = 40;
      repeat (k) begin
        if ($urandom_range(0, 19) == 0)
          send(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
        else send(K_TICK, $urandom, 1'($urandom_range(0, 1)));
      end
      done_items += n + 1 + k;
      quiet = 0;
    end
  endtask

  initial begin
    p_interval = 10000;
    p_spr = 3200;
    p_posmode = 0;
    now_t = 0; next_iv = 0; next_st = 0; period = 0; left = 0;
    dir_q = 0; active = 0; last_taken = 0; have_ref = 0;
    ref_angle = 0; residue = 0; head = 0; count = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(K_TICK, 0, 0);
    test_step_mode_basic();
    test_queue_full();
    test_extremes();
    test_position_mode();
    test_random();
    drain();
    if (errors == 0) begin
      $display("tb_stepper_segment_pulse_executor_unit: done, clean");
    end else begin
      $display("tb_stepper_segment_pulse_executor_unit: done, errors");
    end
    $finish;
  end
endmodule
